// ----- hw/rtl/prl_pkg.sv -----
// Package: register indexes, reset values, configuration record and width defaults.
package prl_pkg;

  localparam int KARMA_WIDTH_DEF = 16;
  localparam int BYTES_WIDTH_DEF = 32;

  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int READ_WIDTH     = 16;
  localparam int TIME_WIDTH     = 32;
  localparam int STEP_WIDTH     = 15;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_KARMA     = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_INC_STEP      = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DEC_STEP      = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PENALTY_VALUE = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RESTORE_VALUE = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BYTES_PER_K   = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HEARTBEAT     = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_START_VALUE   = 3'd7;

  localparam logic signed [15:0] MAX_KARMA_RST     = 16'sd10;
  localparam logic [STEP_WIDTH-1:0] INC_STEP_RST   = 15'd1;
  localparam logic [STEP_WIDTH-1:0] DEC_STEP_RST   = 15'd0;
  localparam logic signed [15:0] PENALTY_VALUE_RST = -16'sd5;
  localparam logic signed [15:0] RESTORE_VALUE_RST = 16'sd5;
  localparam logic [15:0] BYTES_PER_K_RST          = 16'd100;
  localparam logic [15:0] HEARTBEAT_RST            = 16'd2;
  localparam logic signed [15:0] START_VALUE_RST   = 16'sd5;

  typedef struct packed {
    logic signed [15:0]    max_karma;
    logic [STEP_WIDTH-1:0] inc_step;
    logic [STEP_WIDTH-1:0] dec_step;
    logic signed [15:0]    penalty_value;
    logic signed [15:0]    restore_value;
    logic [15:0]           bytes_per_karma;
    logic [15:0]           heartbeat_seconds;
  } prl_cfg_t;

endpackage

// ----- hw/rtl/prl_report_if.sv -----
// Interface: read report channel (byte count and current time).
interface prl_report_if import prl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [READ_WIDTH-1:0] byte_count;
  logic [TIME_WIDTH-1:0] now_seconds;

  modport source (output valid, output byte_count, output now_seconds, input ready);
  modport sink   (input valid, input byte_count, input now_seconds, output ready);
endinterface

// ----- hw/rtl/prl_result_if.sv -----
// Interface: result channel (over-limit flag, karma and byte backlog).
interface prl_result_if #(
  parameter int KARMA_WIDTH = 16,
  parameter int BYTES_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic                          over_limit;
  logic signed [KARMA_WIDTH-1:0] karma_now;
  logic [BYTES_WIDTH-1:0]        byte_backlog;

  modport source (output valid, output over_limit, output karma_now, output byte_backlog,
                  input ready);
  modport sink   (input valid, input over_limit, input karma_now, input byte_backlog,
                  output ready);
endinterface

// ----- hw/rtl/prl_cfg_if.sv -----
// Interface: configuration write channel (register index and data).
interface prl_cfg_if import prl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/prl_cfg_regs.sv -----
// Configuration register file written over the configuration channel.
module prl_cfg_regs import prl_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  prl_cfg_if.sink       cfg,
  output prl_cfg_t      regs
);

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_karma         <= MAX_KARMA_RST;
      regs.inc_step          <= INC_STEP_RST;
      regs.dec_step          <= DEC_STEP_RST;
      regs.penalty_value     <= PENALTY_VALUE_RST;
      regs.restore_value     <= RESTORE_VALUE_RST;
      regs.bytes_per_karma   <= BYTES_PER_K_RST;
      regs.heartbeat_seconds <= HEARTBEAT_RST;
    end else if (wr) begin
      // start value only matters at reset, which reloads its default; drop its writes
      unique case (cfg.index)
        REG_MAX_KARMA:     regs.max_karma         <= signed'(cfg.data);
        REG_INC_STEP:      regs.inc_step          <= cfg.data[STEP_WIDTH-1:0];
        REG_DEC_STEP:      regs.dec_step          <= cfg.data[STEP_WIDTH-1:0];
        REG_PENALTY_VALUE: regs.penalty_value     <= signed'(cfg.data);
        REG_RESTORE_VALUE: regs.restore_value     <= signed'(cfg.data);
        REG_BYTES_PER_K:   regs.bytes_per_karma   <= cfg.data;
        REG_HEARTBEAT:     regs.heartbeat_seconds <= cfg.data;
        REG_START_VALUE:   ;
        default:           ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/prl_core.sv -----
// Update core: input register, karma/backlog update and result register.
module prl_core import prl_pkg::*; #(
  parameter int KARMA_WIDTH = KARMA_WIDTH_DEF,
  parameter int BYTES_WIDTH = BYTES_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  prl_cfg_t     regs,
  prl_report_if.sink   report,
  prl_result_if.source result
);

  localparam int KW = KARMA_WIDTH;
  localparam int BW = BYTES_WIDTH;
  localparam int EW = ((KW > 16) ? KW : 16) + 2;
  localparam int AW = KW + 16;
  localparam int CW = ((AW > BW) ? AW : BW) + 1;

  localparam logic signed [EW-1:0] KHI = {{(EW-KW+1){1'b0}}, {(KW-1){1'b1}}};
  localparam logic signed [EW-1:0] KLO = {{(EW-KW+1){1'b1}}, {(KW-1){1'b0}}};

  function automatic logic signed [KW-1:0] sat_k(input logic signed [EW-1:0] x);
    logic signed [KW-1:0] r;
    if (x > KHI)      r = KHI[KW-1:0];
    else if (x < KLO) r = KLO[KW-1:0];
    else              r = x[KW-1:0];
    return r;
  endfunction

  function automatic logic [AW-1:0] allow(input logic signed [KW-1:0] v,
                                          input logic [15:0] bpk);
    logic [KW-1:0] mag;
    mag = (v < 0) ? KW'(-v) : KW'(v);
    return AW'(mag) * AW'(bpk);
  endfunction

  // Input register
  logic                  in_valid;
  logic [READ_WIDTH-1:0] in_bytes;
  logic [TIME_WIDTH-1:0] in_now;
  logic                  advance;

  // State
  logic signed [KW-1:0]  karma;
  logic [BW-1:0]         backlog;
  logic [TIME_WIDTH-1:0] last_time;

  // Result register
  logic                  res_valid;
  logic                  res_over;
  logic signed [KW-1:0]  res_karma;
  logic [BW-1:0]         res_backlog;

  assign advance      = in_valid && (!res_valid || result.ready);
  assign report.ready = !in_valid || advance;

  // Update logic
  logic                  beat;
  logic signed [EW-1:0]  v0_w;
  logic signed [EW-1:0]  inc_w;
  logic signed [EW-1:0]  v_inc;
  logic                  ends;
  logic signed [KW-1:0]  v_sat;
  logic signed [KW-1:0]  cap;
  logic signed [KW-1:0]  v_clamp;
  logic signed [KW-1:0]  rest_k;
  logic signed [KW-1:0]  pen_k;
  logic [AW-1:0]         a_old;
  logic [AW-1:0]         a_clamp;
  logic [AW-1:0]         a_rest;
  logic [CW-1:0]         a_drain;
  logic [CW-1:0]         a_v1;
  logic [CW-1:0]         bt_c;
  logic [BW-1:0]         bt1;
  logic [BW:0]           bt_sum;
  logic [BW-1:0]         bt2;
  logic signed [KW-1:0]  v1;
  logic signed [KW-1:0]  v_dec;
  logic signed [KW-1:0]  karma_next;
  logic [BW-1:0]         backlog_next;
  logic [TIME_WIDTH-1:0] last_time_next;

  always_comb begin
    beat    = ((TIME_WIDTH+1)'(last_time) + (TIME_WIDTH+1)'(regs.heartbeat_seconds)
               < (TIME_WIDTH+1)'(in_now)) || (last_time == '0);
    v0_w    = EW'(karma);
    inc_w   = EW'(regs.inc_step);
    v_inc   = v0_w + inc_w;
    ends    = (karma < 0) && (v_inc > 0);
    v_sat   = sat_k(v_inc);
    cap     = sat_k(EW'(regs.max_karma));
    v_clamp = (v_sat > cap) ? cap : v_sat;
    rest_k  = sat_k(EW'(regs.restore_value));
    pen_k   = sat_k(EW'(regs.penalty_value));

    // three allowances side by side: old karma, clamped karma, restore value
    a_old   = allow(karma, regs.bytes_per_karma);
    a_clamp = allow(v_clamp, regs.bytes_per_karma);
    a_rest  = allow(rest_k, regs.bytes_per_karma);
    a_drain = CW'(a_clamp);
    bt_c    = CW'(backlog);

    if (beat) begin
      if (v_clamp > 0) begin
        bt1 = (a_drain >= bt_c) ? '0 : BW'(bt_c - a_drain);
      end else begin
        bt1 = backlog;
      end
      v1             = ends ? rest_k : v_clamp;
      a_v1           = ends ? CW'(a_rest) : CW'(a_clamp);
      last_time_next = in_now;
    end else begin
      bt1            = backlog;
      v1             = karma;
      a_v1           = CW'(a_old);
      last_time_next = last_time;
    end

    bt_sum = {1'b0, bt1} + (BW+1)'(in_bytes);
    bt2    = bt_sum[BW] ? '1 : bt_sum[BW-1:0];

    v_dec = sat_k(EW'(v1) - EW'(regs.dec_step));
    if (CW'(bt2) > a_v1) begin
      karma_next = (v_dec <= 0) ? pen_k : v_dec;
    end else begin
      karma_next = v1;
    end
    backlog_next = bt2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (report.valid && report.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report.valid && report.ready) begin
      in_bytes <= report.byte_count;
      in_now   <= report.now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      karma     <= sat_k(EW'(START_VALUE_RST));
      backlog   <= '0;
      last_time <= '0;
    end else if (advance) begin
      karma     <= karma_next;
      backlog   <= backlog_next;
      last_time <= last_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_over    <= (karma_next <= 0);
      res_karma   <= karma_next;
      res_backlog <= backlog_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.over_limit   = res_over;
  assign result.karma_now    = res_karma;
  assign result.byte_backlog = res_backlog;

endmodule

// ----- hw/rtl/penalty_rate_limiter.sv -----
// Top level: karma-based byte rate limiter for read reports.
//
// Usage:
//   report - read reports in: byte_count and now_seconds, one word per report.
//   result - one word out per report: over_limit, karma_now, byte_backlog.
//   cfg    - register writes: index 0..7 selects max karma, increment step,
//            decrement step, penalty value, restore value, bytes per karma,
//            heartbeat period and start value. Always ready; write only while
//            no report is in flight. Start value takes effect at reset only.
// Path: an accepted report is captured in the input register, then the update
//   writes its result word into the result register.
// Throughput: one report per cycle while result.ready stays high; the karma/backlog
//   update is combinational, bounded by a 16-bit by karma-width allowance multiply
//   feeding the backlog drain, saturating add and compare.
// Reset (rst, synchronous): karma loads the default start value, the backlog
//   and last heartbeat time clear, registers take their defaults, and both
//   channel stages empty.
// Stall: with result.ready low, one more report is held in the input register;
//   report.ready then drops until the result word is taken.
module penalty_rate_limiter import prl_pkg::*; #(
  parameter int KARMA_WIDTH = KARMA_WIDTH_DEF,
  parameter int BYTES_WIDTH = BYTES_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  prl_cfg_if.sink      cfg,
  prl_report_if.sink   report,
  prl_result_if.source result
);

  prl_cfg_t regs;

  // Register file
  prl_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Update core: holds the karma, backlog and last-heartbeat state
  prl_core #(
    .KARMA_WIDTH (KARMA_WIDTH),
    .BYTES_WIDTH (BYTES_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .report (report),
    .result (result)
  );

endmodule
